[rtl/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and codes for the sorted region table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CONFLICT  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_RANGE = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] start_address;
    logic [31:0] length;
  } srt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [5:0]  slot;
    logic [31:0] hit_start;
    logic [31:0] hit_length;
    logic [6:0]  occupancy;
  } srt_out_t;

endpackage

[rtl/srt_ram.sv]
// ----------------------------------------------------------------------------
// srt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sorted_region_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_region_table_unit
// Sorted, non-overlapping region table with insert, find and delete.
// ----------------------------------------------------------------------------
// flow: bad range, reserved kind, or a full table on insert go straight to
//   the result beat; otherwise a non-empty table is scanned from the top down,
//   then insert or delete moves entries and a successful insert writes the new
//   entry; scan and moves read the table RAM, whose read is registered.
// throughput: one item at a time, busy is high until the result beat.
// reset: synchronous active low, table empty, no result pending.
module sorted_region_table_unit #(
  parameter int CAPACITY  = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  srt_pkg::srt_in_t  in_item,
  output logic              busy,
  output logic              out_valid,
  output srt_pkg::srt_out_t out_item
);
  import srt_pkg::*;

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int LIM = (ADDR_BITS > 33) ? 33 : ADDR_BITS;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SRD  = 8'b0000_0010,
    S_SCMP = 8'b0000_0100,
    S_RES  = 8'b0000_1000,
    S_MRD  = 8'b0001_0000,
    S_MWR  = 8'b0010_0000,
    S_INS  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic [31:0]    s_r, s_nxt, len_r, len_nxt, hs_r, hs_nxt, hl_r, hl_nxt;
  logic [32:0]    last_r, last_nxt;
  logic [IW-1:0]  idx_r, idx_nxt, dst_r, dst_nxt, pos_r, pos_nxt;
  logic           cand_r, cand_nxt, ov_r, ov_nxt;
  srt_out_t       res_r, res_nxt;

  logic [32:0]    last_w;
  logic           range_ok;
  logic [63:0]    rd_data, wr_data;
  logic [31:0]    rd_start, rd_len;
  logic [IW-1:0]  rd_addr, wr_addr;
  logic           wr_en;
  logic [IW-1:0]  dst_dn, dst_up;

  assign last_w   = {1'b0, in_item.start_address} + {1'b0, in_item.length} - 33'd1;
  assign range_ok = (in_item.length != 32'd0) && ((last_w >> LIM) == 33'd0);
  assign rd_start = rd_data[63:32];
  assign rd_len   = rd_data[31:0];
  assign dst_dn   = dst_r - IW'(1);
  assign dst_up   = dst_r + IW'(1);

  srt_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // memory port steering
  always_comb begin
    rd_addr = idx_r;
    wr_en   = 1'b0;
    wr_addr = dst_r;
    wr_data = rd_data;
    if (state_r == S_MRD) begin
      rd_addr = (kind_r == KIND_INSERT) ? dst_dn : dst_up;
    end
    if (state_r == S_MWR) begin
      wr_en = 1'b1;
    end
    if (state_r == S_INS) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = {s_r, len_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    kind_nxt      = kind_r;
    s_nxt         = s_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    hs_nxt        = hs_r;
    hl_nxt        = hl_r;
    idx_nxt       = idx_r;
    dst_nxt       = dst_r;
    pos_nxt       = pos_r;
    cand_nxt      = cand_r;
    ov_nxt        = ov_r;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_item.kind;
          s_nxt     = in_item.start_address;
          len_nxt   = in_item.length;
          last_nxt  = last_w;
          res_nxt   = '0;
          res_nxt.occupancy = 7'(count_r);
          cand_nxt  = 1'b0;
          ov_nxt    = 1'b0;
          if (!range_ok || in_item.kind == KIND_RSVD) begin
            res_nxt.status = ST_BAD_RANGE;
            state_nxt      = S_FIN;
          end else if (in_item.kind == KIND_INSERT && count_r == CAP_C) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_FIN;
          end else if (count_r == '0) begin
            state_nxt = S_RES;
          end else begin
            idx_nxt   = IW'(count_r - CW'(1));
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        // top-down scan: first entry starting at or below the range end
        if ({1'b0, rd_start} <= last_r) begin
          cand_nxt  = 1'b1;
          ov_nxt    = {1'b0, s_r} <= ({1'b0, rd_start} + {1'b0, rd_len} - 33'd1);
          hs_nxt    = rd_start;
          hl_nxt    = rd_len;
          state_nxt = S_RES;
        end else if (idx_r == '0) begin
          state_nxt = S_RES;
        end else begin
          idx_nxt   = idx_r - IW'(1);
          state_nxt = S_SRD;
        end
      end
      S_RES: begin
        state_nxt = S_FIN;
        priority if (kind_r == KIND_INSERT) begin
          if (ov_r) begin
            res_nxt.status = ST_CONFLICT;
          end else begin
            pos_nxt   = cand_r ? (idx_r + IW'(1)) : '0;
            dst_nxt   = IW'(count_r);
            state_nxt = (IW'(count_r) == pos_nxt) ? S_INS : S_MRD;
          end
        end else if (kind_r == KIND_FIND) begin
          if (ov_r) begin
            res_nxt.status     = ST_OK;
            res_nxt.found      = 1'b1;
            res_nxt.slot       = 6'(idx_r);
            res_nxt.hit_start  = hs_r;
            res_nxt.hit_length = hl_r;
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
        end else begin
          if (ov_r && hs_r == s_r && hl_r == len_r) begin
            res_nxt.status    = ST_OK;
            res_nxt.found     = 1'b1;
            res_nxt.slot      = 6'(idx_r);
            count_nxt         = count_r - CW'(1);
            res_nxt.occupancy = 7'(count_nxt);
            dst_nxt           = idx_r;
            // close the gap only when entries sit above the removed one
            if (CW'(idx_r) < count_nxt) begin
              state_nxt = S_MRD;
            end
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
        end
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: begin
        if (kind_r == KIND_INSERT) begin
          dst_nxt   = dst_dn;
          state_nxt = (dst_dn == pos_r) ? S_INS : S_MRD;
        end else begin
          dst_nxt   = dst_up;
          state_nxt = ((CW'(dst_r) + CW'(1)) < count_r) ? S_MRD : S_FIN;
        end
      end
      S_INS: begin
        count_nxt         = count_r + CW'(1);
        res_nxt.status    = ST_OK;
        res_nxt.slot      = 6'(pos_r);
        res_nxt.occupancy = 7'(count_nxt);
        state_nxt         = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    s_r    <= s_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
    hs_r   <= hs_nxt;
    hl_r   <= hl_nxt;
    idx_r  <= idx_nxt;
    dst_r  <= dst_nxt;
    pos_r  <= pos_nxt;
    cand_r <= cand_nxt;
    ov_r   <= ov_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

endmodule

[rtl/srt_checker.sv]
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks for the sorted region table, bound to the top level.
// ----------------------------------------------------------------------------
module srt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input srt_pkg::srt_out_t out_item
);
  import srt_pkg::*;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_out_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  a_out_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.slot == '0 && !out_item.found)
    else $error("failed result carries slot or found");

  a_found_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.found |-> out_item.status == ST_OK)
    else $error("found set on failed result");

endmodule

bind sorted_region_table_unit srt_checker u_srt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[tb/sorted_region_table_unit_checker.sv]
// ----------------------------------------------------------------------------
// sorted_region_table_unit_checker
// Watches the command and result beats of the region table, keeps its own
// copy of the sorted table, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module sorted_region_table_unit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  srt_pkg::srt_in_t  in_item,
  input  logic              out_valid,
  input  srt_pkg::srt_out_t out_item,
  output int                errors,
  output int                pending
);
  import srt_pkg::*;

  localparam int SLOTS = 64;

  logic [31:0] tbl_start [SLOTS];
  logic [31:0] tbl_len   [SLOTS];
  int          tbl_count;
  srt_out_t    expected_q[$];

  initial begin
    errors    = 0;
    pending   = 0;
    tbl_count = 0;
  end

  // index of the highest-start stored region overlapping [s, last], or -1
  function automatic int overlap_index(logic [31:0] s, logic [31:0] last);
    int i;
    i = tbl_count - 1;
    while (i >= 0 && tbl_start[i] > last) i--;
    if (i >= 0 && s <= tbl_start[i] + (tbl_len[i] - 32'd1)) return i;
    return -1;
  endfunction

  function automatic srt_out_t apply_command(srt_in_t c);
    srt_out_t    r;
    logic [32:0] last_wide;
    logic [31:0] last;
    logic        range_ok;
    int          i;
    int          pos;
    r = '0;
    r.status  = ST_BAD_RANGE;
    last_wide = {1'b0, c.start_address} + {1'b0, c.length} - 33'd1;
    last      = last_wide[31:0];
    range_ok  = (c.length != 0) && !last_wide[32];
    if (range_ok && c.kind == KIND_INSERT) begin
      if (tbl_count >= SLOTS) begin
        r.status = ST_FULL;
      end else if (overlap_index(c.start_address, last) >= 0) begin
        r.status = ST_CONFLICT;
      end else begin
        pos = 0;
        while (pos < tbl_count && tbl_start[pos] < c.start_address) pos++;
        for (i = tbl_count; i > pos; i--) begin
          tbl_start[i] = tbl_start[i-1];
          tbl_len[i]   = tbl_len[i-1];
        end
        tbl_start[pos] = c.start_address;
        tbl_len[pos]   = c.length;
        tbl_count++;
        r.status = ST_OK;
        r.slot   = pos[5:0];
      end
    end else if (range_ok && c.kind == KIND_FIND) begin
      i = overlap_index(c.start_address, last);
      if (i >= 0) begin
        r.status     = ST_OK;
        r.found      = 1'b1;
        r.slot       = i[5:0];
        r.hit_start  = tbl_start[i];
        r.hit_length = tbl_len[i];
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (range_ok && c.kind == KIND_DELETE) begin
      i = overlap_index(c.start_address, last);
      if (i >= 0 && tbl_start[i] == c.start_address && tbl_len[i] == c.length) begin
        r.status = ST_OK;
        r.found  = 1'b1;
        r.slot   = i[5:0];
        for (pos = i; pos + 1 < tbl_count; pos++) begin
          tbl_start[pos] = tbl_start[pos+1];
          tbl_len[pos]   = tbl_len[pos+1];
        end
        tbl_count--;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.occupancy = tbl_count[6:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    srt_out_t e;
    if (rst_n) begin
      if (start && !busy) expected_q.push_back(apply_command(in_item));
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_item);
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("status",     e.status,     out_item.status);
          check_field("found",      e.found,      out_item.found);
          check_field("slot",       e.slot,       out_item.slot);
          check_field("hit_start",  e.hit_start,  out_item.hit_start);
          check_field("hit_length", e.hit_length, out_item.hit_length);
          check_field("occupancy",  e.occupancy,  out_item.occupancy);
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

[tb/sorted_region_table_unit_test.sv]
// ----------------------------------------------------------------------------
// sorted_region_table_unit_test
// Drives insert, find and delete commands into the region table, with
// directed edge cases, table fill and drain runs and random traffic; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module sorted_region_table_unit_test;
  import srt_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  srt_in_t   in_item = '0;
  logic      busy;
  logic      out_valid;
  srt_out_t  out_item;
  int        errors;
  int        pending;
  srt_in_t   inserted_q[$];

  always #6 clk = ~clk;

  sorted_region_table_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item)
  );

  sorted_region_table_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .errors(errors), .pending(pending)
  );

  function automatic srt_in_t make_cmd(logic [1:0] k, logic [31:0] s, logic [31:0] l);
    srt_in_t c;
    c.kind = k;
    c.start_address = s;
    c.length = l;
    return c;
  endfunction

  // hold start low for a random gap, then present the beat until accepted
  task automatic send(srt_in_t c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
    if (c.kind == KIND_INSERT) begin
      inserted_q.push_back(c);
      if (inserted_q.size() > 96) void'(inserted_q.pop_front());
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic srt_in_t random_cmd();
    srt_in_t c;
    int      sel;
    int      mode;
    sel  = $urandom_range(0, 99);
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      c.start_address = $urandom_range(0, 4095);
      c.length        = $urandom_range(1, 64);
    end else if (mode < 8) begin
      c.start_address = $urandom;
      c.length        = $urandom >> $urandom_range(0, 31);
    end else begin
      c.start_address = 32'hFFFF_FFFF - $urandom_range(0, 300);
      c.length        = $urandom_range(0, 320);
    end
    if (sel < 45) begin
      c.kind = KIND_INSERT;
    end else if (sel < 72) begin
      c.kind = KIND_FIND;
    end else if (sel < 95) begin
      c.kind = KIND_DELETE;
      if (inserted_q.size() > 0 && $urandom_range(0, 3) != 0)
        c = make_cmd(KIND_DELETE,
                     inserted_q[$urandom_range(0, inserted_q.size() - 1)].start_address,
                     inserted_q[$urandom_range(0, inserted_q.size() - 1)].length);
      if (inserted_q.size() > 0 && $urandom_range(0, 1) == 0) begin
        c = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
        c.kind = KIND_DELETE;
      end
    end else begin
      c.kind = KIND_RSVD;
    end
    return c;
  endfunction

  // fill the table past capacity in a region of its own, probe, then empty it
  task automatic fill_and_empty();
    int i;
    for (i = 0; i < 68; i++)
      send(make_cmd(KIND_INSERT, 32'h8000_0000 + i * 32, 32'd16));
    send(make_cmd(KIND_FIND, 32'h8000_0000, 32'd4096));
    send(make_cmd(KIND_INSERT, 32'h0000_0000, 32'd1));
    for (i = 67; i >= 0; i--)
      send(make_cmd(KIND_DELETE, 32'h8000_0000 + i * 32, 32'd16));
    for (i = 0; i < 70; i++) send(make_cmd(KIND_DELETE, $urandom_range(0, 4095), 32'd1));
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range edges, every kind, misses and partial matches
    send(make_cmd(KIND_FIND,   32'h0000_0000, 32'h0000_0000));
    send(make_cmd(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0002));
    send(make_cmd(KIND_DELETE, 32'h0000_0001, 32'hFFFF_FFFF));
    send(make_cmd(KIND_RSVD,   32'h0000_1000, 32'h0000_0010));
    send(make_cmd(KIND_FIND,   32'h0000_1000, 32'h0000_0010));
    send(make_cmd(KIND_DELETE, 32'h0000_1000, 32'h0000_0010));
    send(make_cmd(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0001));
    send(make_cmd(KIND_INSERT, 32'h0000_1000, 32'h0000_0010));
    send(make_cmd(KIND_INSERT, 32'h0000_0000, 32'h0000_0100));
    send(make_cmd(KIND_INSERT, 32'h0000_1008, 32'h0000_0010));
    send(make_cmd(KIND_INSERT, 32'h0000_0FF8, 32'h0000_0009));
    send(make_cmd(KIND_INSERT, 32'h0000_1010, 32'h0000_0004));
    send(make_cmd(KIND_FIND,   32'h0000_0000, 32'hFFFF_FFFF));
    send(make_cmd(KIND_FIND,   32'h0000_100F, 32'h0000_0001));
    send(make_cmd(KIND_FIND,   32'h0000_2000, 32'h0000_0010));
    send(make_cmd(KIND_FIND,   32'hFFFF_FFF0, 32'h0000_0010));
    send(make_cmd(KIND_DELETE, 32'h0000_1000, 32'h0000_0008));
    send(make_cmd(KIND_DELETE, 32'h0000_1004, 32'h0000_0010));
    send(make_cmd(KIND_DELETE, 32'h0000_1000, 32'h0000_0010));
    send(make_cmd(KIND_DELETE, 32'hFFFF_FFFF, 32'h0000_0001));
    send(make_cmd(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF));
    drain();

    fill_and_empty();
    drain();

    for (n = 0; n < 1300; n++) begin
      send(random_cmd());
      if (n % 600 == 300) fill_and_empty();
      if (n % 250 == 0) drain();
    end

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("sorted_region_table_unit verification clean");
    end else begin
      $display("sorted_region_table_unit verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("sorted_region_table_unit verification failed");
    $finish;
  end

endmodule
